// File: rtl/fbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbt_pkg: shared types and constants of the belief triangulation block
// Widths, register indexes, the sequencer state type and the control
// bundle that the sequencer drives into every entry cell.
// ----------------------------------------------------------------------------
package fbt_pkg;

    // Sizes of the entry row and of the data fields.
    localparam int MAX_ENTRIES = 8;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 4;
    localparam int STATE_W     = 16;
    localparam int PROB_W      = 17;
    localparam int FRAC_W      = 16;
    localparam int RES_W       = 8;
    localparam int TOL_W       = 16;
    localparam int FLOOR_W     = RES_W + 1;
    localparam int PROD_W      = PROB_W + RES_W;
    localparam int WEIGHT_W    = FRAC_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // The value one in the fraction format.
    localparam logic [WEIGHT_W-1:0] ONE_F = WEIGHT_W'(1) << FRAC_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DYNAMIC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SMUL,
        S_SEVAL,
        S_CMUL,
        S_CHAIN,
        S_RANK,
        S_VSEL,
        S_VEMIT,
        S_FLUSH
    } t_state;

    // Control bundle broadcast to the cells.
    typedef struct packed {
        logic load;
        logic set_one;
        logic latch;
        logic inc;
        logic rank_clr;
        logic rank_step;
    } t_cell_ctl;

endpackage

// File: rtl/fbt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbt_cell: one entry cell of the triangulation row
// Holds the state index, probability, grid floor, fraction and sort rank of
// one belief entry, and works out its own product, miss flag and numerator.
// ----------------------------------------------------------------------------
module fbt_cell
    import fbt_pkg::*;
(
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic                i_sel,
    input  logic [IDX_W-1:0]    i_idx,
    input  logic [CNT_W-1:0]    i_cnt,
    input  logic [STATE_W-1:0]  i_state,
    input  logic [PROB_W-1:0]   i_prob,
    input  logic [RES_W-1:0]    i_r,
    input  logic [TOL_W-1:0]    i_tol,
    input  logic [PROD_W-1:0]   i_x,
    input  logic [IDX_W-1:0]    i_bc_idx,
    input  logic [FRAC_W-1:0]   i_bc_frac,
    input  logic [FLOOR_W-1:0]  i_floor_next,
    output logic [PROD_W-1:0]   o_prod,
    output logic                o_miss,
    output logic                o_active,
    output logic [FLOOR_W-1:0]  o_floor,
    output logic [FRAC_W-1:0]   o_frac,
    output logic [IDX_W-1:0]    o_rank,
    output logic [STATE_W-1:0]  o_state,
    output logic [FLOOR_W-1:0]  o_num
);

    logic [STATE_W-1:0]  r_state;
    logic [PROB_W-1:0]   r_prob;
    logic [PROD_W-1:0]   r_prod;
    logic [FLOOR_W-1:0]  r_floor;
    logic [FRAC_W-1:0]   r_frac;
    logic [IDX_W-1:0]    r_rank;
    logic                w_active;
    logic [WEIGHT_W-1:0] w_f;
    logic [WEIGHT_W-1:0] w_fc;
    logic [WEIGHT_W-1:0] w_dist;
    logic                w_beats;

    assign w_active = {1'b0, i_idx} < i_cnt;

    // Distance of the scaled probability to the nearest integer.
    assign w_f    = {1'b0, r_prod[FRAC_W-1:0]};
    assign w_fc   = ONE_F - w_f;
    assign w_dist = (w_f <= w_fc) ? w_f : w_fc;

    // The broadcast entry sorts ahead of this one: larger fraction, or equal
    // fraction at a lower position.
    assign w_beats = (i_bc_idx != i_idx) &&
                     ((i_bc_frac > r_frac) || ((i_bc_frac == r_frac) && (i_bc_idx < i_idx)));

    // Product of the probability and the broadcast resolution.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_prob) * PROD_W'(i_r);
    end

    // Entry storage and triangulation values.
    always_ff @(posedge i_clk) begin
        if (i_sel && i_ctl.load) begin
            r_state <= i_state;
            r_prob  <= i_prob;
        end
        if (i_sel && i_ctl.set_one) begin
            r_prob <= PROB_W'(ONE_F);
        end
        if (i_sel && i_ctl.latch) begin
            r_floor <= w_active ? {1'b0, i_x[FRAC_W+RES_W-1:FRAC_W]} : '0;
            r_frac  <= i_x[FRAC_W-1:0];
        end
        if (i_sel && i_ctl.inc) begin
            r_floor <= r_floor + FLOOR_W'(1);
        end
        if (i_ctl.rank_clr) begin
            r_rank <= '0;
        end else if (i_ctl.rank_step && w_beats) begin
            r_rank <= r_rank + IDX_W'(1);
        end
    end

    assign o_prod   = r_prod;
    assign o_miss   = w_active && (w_dist > {1'b0, i_tol});
    assign o_active = w_active;
    assign o_floor  = r_floor;
    assign o_frac   = r_frac;
    assign o_rank   = r_rank;
    assign o_state  = r_state;
    assign o_num    = r_floor - i_floor_next;

endmodule

// File: rtl/freudenthal_belief_triangulation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// freudenthal_belief_triangulation_top: grid triangulation of one belief
// Collects belief entries into a row of cells and emits the grid vertices
// of the Freudenthal triangulation with their barycentric weights.
// ----------------------------------------------------------------------------
// An entry is taken on each i_start while o_busy is low; the final entry of a
// belief (or the eighth) starts the triangulation and raises o_busy until the
// cycle in which the last result is on the outputs. In dynamic mode the run
// first searches the resolution (up to (N+1)/2 candidates), then works the
// floor chain and the rank pass, and for each sorted step selects a vertex
// and emits it if it is kept, between a setup and a flush state.
// Results appear on o_valid for one cycle each, with no back pressure, so the
// receiver must take every strobe. Configuration writes are always ready and
// belong in the idle time between beliefs.
module freudenthal_belief_triangulation_top
    import fbt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [STATE_W-1:0]    i_state_index,
    input  logic [PROB_W-1:0]     i_probability,
    input  logic                  i_last_entry,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic [WEIGHT_W-1:0]   o_vertex_weight,
    output logic [STATE_W-1:0]    o_entry_state,
    output logic [RES_W-1:0]      o_entry_numerator,
    output logic [RES_W-1:0]      o_used_resolution,
    output logic                  o_vertex_end,
    output logic                  o_last
);

    t_state r_st, n_st;

    logic [RES_W-1:0]    r_res;
    logic                r_dyn;
    logic [TOL_W-1:0]    r_tol;
    logic [CNT_W-1:0]    r_cnt;
    logic [RES_W-1:0]    r_n;
    logic [RES_W-1:0]    r_r;
    logic [RES_W-1:0]    r_best;
    logic [CNT_W-1:0]    r_bm;
    logic [PROD_W-1:0]   r_x;
    logic [IDX_W-1:0]    r_k;
    logic [IDX_W-1:0]    r_i;
    logic [IDX_W-1:0]    r_prev;
    logic [IDX_W-1:0]    r_cur;
    logic [WEIGHT_W-1:0] r_w;
    logic                r_vfirst;
    logic                r_p_valid;
    logic [WEIGHT_W-1:0] r_p_w;
    logic [STATE_W-1:0]  r_p_state;
    logic [RES_W-1:0]    r_p_num;
    logic                r_o_valid;
    logic [WEIGHT_W-1:0] r_o_w;
    logic [STATE_W-1:0]  r_o_state;
    logic [RES_W-1:0]    r_o_num;
    logic [RES_W-1:0]    r_o_res;
    logic                r_o_vend;
    logic                r_o_last;

    t_cell_ctl              w_ctl;
    logic [MAX_ENTRIES-1:0] w_sel;
    logic [PROD_W-1:0]      w_prod   [MAX_ENTRIES];
    logic [FLOOR_W-1:0]     w_floor  [MAX_ENTRIES];
    logic [FLOOR_W-1:0]     w_fnext  [MAX_ENTRIES];
    logic [FRAC_W-1:0]      w_frac   [MAX_ENTRIES];
    logic [IDX_W-1:0]       w_rank   [MAX_ENTRIES];
    logic [STATE_W-1:0]     w_cstate [MAX_ENTRIES];
    logic [FLOOR_W-1:0]     w_num    [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_miss;
    logic [MAX_ENTRIES-1:0] w_active;
    logic [CNT_W-1:0]       w_miss_cnt;
    logic                   w_worse;
    logic                   w_search_done;
    logic [RES_W:0]         w_twice_next;
    logic [IDX_W-1:0]       w_last_idx;
    logic                   w_accept_final;
    logic [IDX_W-1:0]       w_cur_enc;
    logic [IDX_W-1:0]       w_tail_enc;
    logic [IDX_W-1:0]       w_prev_eff;
    logic [WEIGHT_W-1:0]    w_weight;
    logic                   w_keep;
    logic [PROD_W-1:0]      w_step;
    logic [IDX_W-1:0]       w_bc_idx;
    logic [FLOOR_W-1:0]     w_num_j;
    logic                   w_new_res;

    assign w_last_idx     = r_cnt[IDX_W-1:0] - IDX_W'(1);
    assign w_accept_final = i_last_entry || (r_cnt == CNT_W'(MAX_ENTRIES - 1));

    // Row of entry cells; each cell sees its right neighbor's floor.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        if (g < MAX_ENTRIES - 1) begin : g_mid
            assign w_fnext[g] = w_floor[g+1];
        end else begin : g_end
            assign w_fnext[g] = '0;
        end
        fbt_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_sel        (w_sel[g]),
            .i_idx        (IDX_W'(g)),
            .i_cnt        (r_cnt),
            .i_state      (i_state_index),
            .i_prob       (i_probability),
            .i_r          (r_r),
            .i_tol        (r_tol),
            .i_x          (r_x),
            .i_bc_idx     (w_bc_idx),
            .i_bc_frac    (w_frac[w_bc_idx]),
            .i_floor_next (w_fnext[g]),
            .o_prod       (w_prod[g]),
            .o_miss       (w_miss[g]),
            .o_active     (w_active[g]),
            .o_floor      (w_floor[g]),
            .o_frac       (w_frac[g]),
            .o_rank       (w_rank[g]),
            .o_state      (w_cstate[g]),
            .o_num        (w_num[g])
        );
    end

    // Sorted-order lookups: the cell at the current step and the tail cell.
    always_comb begin
        w_cur_enc  = '0;
        w_tail_enc = '0;
        for (int c = 0; c < MAX_ENTRIES; c++) begin
            if (w_active[c] && (w_rank[c] == r_i)) begin
                w_cur_enc = IDX_W'(c);
            end
            if (w_active[c] && (w_rank[c] == w_last_idx)) begin
                w_tail_enc = IDX_W'(c);
            end
        end
    end

    assign w_prev_eff = (r_i == '0) ? w_tail_enc : r_prev;
    assign w_weight   = ((r_i == '0) ? ONE_F : '0) + {1'b0, w_frac[w_prev_eff]}
                        - {1'b0, w_frac[w_cur_enc]};
    assign w_keep     = w_weight > {1'b0, r_tol};

    // Resolution search bookkeeping.
    assign w_miss_cnt    = CNT_W'($countones(w_miss));
    assign w_worse       = w_miss_cnt >= r_bm;
    assign w_twice_next  = {r_r - RES_W'(1), 1'b0};
    assign w_search_done = (!w_worse && (w_miss_cnt == '0)) ||
                           !(w_twice_next > {1'b0, r_n});

    assign w_step    = w_prod[r_k];
    assign w_bc_idx  = r_k;
    assign w_num_j   = w_num[r_k];
    assign w_new_res = (w_num_j != '0);

    // Configuration writes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= RES_W'(8);
            r_dyn <= 1'b0;
            r_tol <= TOL_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RESOLUTION: r_res <= i_cfg_data[RES_W-1:0];
                CFG_DYNAMIC:    r_dyn <= i_cfg_data[0];
                CFG_TOLERANCE:  r_tol <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (i_start && w_accept_final) n_st = S_PREP;
            S_PREP:  n_st = ((r_cnt == CNT_W'(1)) || !r_dyn) ? S_CMUL : S_SMUL;
            S_SMUL:  n_st = S_SEVAL;
            S_SEVAL: n_st = w_search_done ? S_CMUL : S_SMUL;
            S_CMUL:  n_st = S_CHAIN;
            S_CHAIN: if (r_k == IDX_W'(MAX_ENTRIES - 1)) n_st = S_RANK;
            S_RANK:  if (r_k == w_last_idx) n_st = S_VSEL;
            S_VSEL: begin
                if (w_keep) begin
                    n_st = S_VEMIT;
                end else if (r_i == w_last_idx) begin
                    n_st = S_FLUSH;
                end
            end
            S_VEMIT: begin
                if (r_k == w_last_idx) begin
                    n_st = (r_i == w_last_idx) ? S_FLUSH : S_VSEL;
                end
            end
            S_FLUSH: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // Cell control outputs.
    always_comb begin
        w_ctl = '0;
        w_sel = '0;
        unique case (r_st)
            S_IDLE: begin
                w_ctl.load = i_start;
                w_sel      = MAX_ENTRIES'(1) << r_cnt[IDX_W-1:0];
            end
            S_PREP: begin
                w_ctl.set_one = (r_cnt == CNT_W'(1));
                w_sel         = MAX_ENTRIES'(1);
            end
            S_CMUL: w_ctl.rank_clr = 1'b1;
            S_CHAIN: begin
                w_ctl.latch = 1'b1;
                w_sel       = MAX_ENTRIES'(1) << r_k;
            end
            S_RANK: w_ctl.rank_step = 1'b1;
            S_VSEL: begin
                w_ctl.inc = (r_i != '0);
                w_sel     = MAX_ENTRIES'(1) << w_prev_eff;
            end
            default: ;
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // Control counters and pending result flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= ((r_st == S_VEMIT && w_new_res) || (r_st == S_FLUSH)) && r_p_valid;
            if (r_st == S_IDLE && i_start) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_st == S_VEMIT && w_new_res) begin
                r_p_valid <= 1'b1;
            end
            if (r_st == S_FLUSH) begin
                r_cnt     <= '0;
                r_p_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_PREP: begin
                r_n    <= (r_res == '0) ? RES_W'(1) : r_res;
                r_r    <= (r_res == '0) ? RES_W'(1) : r_res;
                r_best <= (r_res == '0) ? RES_W'(1) : r_res;
                r_bm   <= r_cnt + CNT_W'(1);
            end
            S_SEVAL: begin
                if (!w_worse) begin
                    r_best <= r_r;
                    r_bm   <= w_miss_cnt;
                end
                if (w_search_done) begin
                    r_r <= w_worse ? r_best : r_r;
                end else begin
                    r_r <= r_r - RES_W'(1);
                end
            end
            S_CMUL: begin
                r_x <= PROD_W'(r_r) << FRAC_W;
                r_k <= '0;
            end
            S_CHAIN: begin
                r_x <= (r_x > w_step) ? r_x - w_step : '0;
                r_k <= (r_k == IDX_W'(MAX_ENTRIES - 1)) ? '0 : r_k + IDX_W'(1);
            end
            S_RANK: begin
                r_k <= r_k + IDX_W'(1);
                r_i <= '0;
            end
            S_VSEL: begin
                r_w      <= w_weight;
                r_cur    <= w_cur_enc;
                r_k      <= '0;
                r_vfirst <= 1'b1;
                if (!w_keep) begin
                    r_prev <= w_cur_enc;
                    r_i    <= r_i + IDX_W'(1);
                end else begin
                    r_prev <= w_prev_eff;
                end
            end
            S_VEMIT: begin
                r_k <= r_k + IDX_W'(1);
                if (r_k == w_last_idx) begin
                    r_prev <= r_cur;
                    r_i    <= r_i + IDX_W'(1);
                end
                if (w_new_res) begin
                    r_p_w     <= r_w;
                    r_p_state <= w_cstate[r_k];
                    r_p_num   <= w_num_j[RES_W-1:0];
                    r_vfirst  <= 1'b0;
                    r_o_w     <= r_p_w;
                    r_o_state <= r_p_state;
                    r_o_num   <= r_p_num;
                    r_o_res   <= r_r;
                    r_o_vend  <= r_vfirst;
                    r_o_last  <= 1'b0;
                end
            end
            S_FLUSH: begin
                r_o_w     <= r_p_w;
                r_o_state <= r_p_state;
                r_o_num   <= r_p_num;
                r_o_res   <= r_r;
                r_o_vend  <= 1'b1;
                r_o_last  <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_busy            = (r_st != S_IDLE);
    assign o_valid           = r_o_valid;
    assign o_vertex_weight   = r_o_w;
    assign o_entry_state     = r_o_state;
    assign o_entry_numerator = r_o_num;
    assign o_used_resolution = r_o_res;
    assign o_vertex_end      = r_o_vend;
    assign o_last            = r_o_last;

endmodule

// File: tb/fbt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbt_checker: result predictor and comparator for the belief triangulation
// Watches the entry, configuration and result channels of the block. It
// keeps its own copy of the entry buffer and of the registers, predicts the
// grid vertices of every finished belief and compares each result strobe
// with the oldest predicted vertex entry.
// ----------------------------------------------------------------------------
module fbt_checker
    import fbt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [STATE_W-1:0]    i_state_index,
    input  logic [PROB_W-1:0]     i_probability,
    input  logic                  i_last_entry,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic [WEIGHT_W-1:0]   i_vertex_weight,
    input  logic [STATE_W-1:0]    i_entry_state,
    input  logic [RES_W-1:0]      i_entry_numerator,
    input  logic [RES_W-1:0]      i_used_resolution,
    input  logic                  i_vertex_end,
    input  logic                  i_last,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_beliefs
);

    localparam logic [63:0] ONE = 64'd1 << FRAC_W;

    // One expected vertex entry.
    typedef struct {
        logic [WEIGHT_W-1:0] weight;
        logic [STATE_W-1:0]  state;
        logic [RES_W-1:0]    numer;
        logic [RES_W-1:0]    res;
        logic                vend;
        logic                fin;
    } t_vertex_entry;

    t_vertex_entry vertex_q[$];

    // Shadow of the entry buffer and of the registers.
    logic [STATE_W-1:0] buf_state [MAX_ENTRIES];
    logic [63:0]        buf_prob  [MAX_ENTRIES];
    int unsigned        buf_count;
    logic [RES_W-1:0]   reg_res;
    logic               reg_dyn;
    logic [TOL_W-1:0]   reg_tol;

    // Resolution search: fewest entries off the grid, stopping at none.
    function automatic logic [63:0] best_resolution(logic [63:0] n, int unsigned cnt,
                                                    logic [63:0] tol);
        logic [63:0] best;
        logic [63:0] r;
        logic [63:0] f;
        logic [63:0] gap;
        int unsigned best_miss;
        int unsigned miss;
        logic        worse;
        best = n;
        best_miss = cnt + 1;
        for (r = n; 2 * r > n; r--) begin
            miss = 0;
            worse = 1'b0;
            for (int k = 0; k < cnt; k++) begin
                f = (buf_prob[k] * r) & (ONE - 1);
                gap = (f <= ONE - f) ? f : ONE - f;
                if (gap > tol) begin
                    miss++;
                    if (miss >= best_miss) begin
                        worse = 1'b1;
                        break;
                    end
                end
            end
            if (!worse) begin
                best = r;
                best_miss = miss;
                if (miss == 0) break;
            end
        end
        return best;
    endfunction

    // Floor chain, descending sort of the fractions and vertex emission.
    task automatic predict_vertices(logic [63:0] r, int unsigned cnt, logic [63:0] tol);
        logic [63:0] x;
        logic [63:0] step;
        logic [63:0] w;
        logic [63:0] num;
        logic [63:0] flr [MAX_ENTRIES+1];
        logic [63:0] frac [MAX_ENTRIES];
        int unsigned ord [MAX_ENTRIES];
        int unsigned pos;
        int unsigned prev;
        int unsigned cur;
        int          first;
        t_vertex_entry e;
        t_vertex_entry local_q[$];
        x = r * ONE;
        for (int k = 0; k < cnt; k++) begin
            step = buf_prob[k] * r;
            flr[k] = x >> FRAC_W;
            frac[k] = x & (ONE - 1);
            x = (x > step) ? x - step : 0;
        end
        flr[cnt] = 0;
        for (int k = 0; k < cnt; k++) begin
            pos = k;
            while (pos > 0 && frac[ord[pos-1]] < frac[k]) begin
                ord[pos] = ord[pos-1];
                pos--;
            end
            ord[pos] = k;
        end
        prev = ord[cnt-1];
        for (int i = 0; i < cnt; i++) begin
            cur = ord[i];
            if (i == 0) begin
                w = ONE + frac[prev] - frac[cur];
            end else begin
                w = frac[prev] - frac[cur];
                flr[prev]++;
            end
            if (w > tol) begin
                first = local_q.size();
                for (int j = 0; j < cnt; j++) begin
                    num = flr[j] - flr[j+1];
                    if (num != 0) begin
                        e.weight = w[WEIGHT_W-1:0];
                        e.state  = buf_state[j];
                        e.numer  = num[RES_W-1:0];
                        e.res    = r[RES_W-1:0];
                        e.vend   = 1'b0;
                        e.fin    = 1'b0;
                        local_q  = {local_q, e};
                    end
                end
                if (local_q.size() > first) local_q[local_q.size()-1].vend = 1'b1;
            end
            prev = cur;
        end
        if (local_q.size() > 0) local_q[local_q.size()-1].fin = 1'b1;
        vertex_q = {vertex_q, local_q};
    endtask

    // Track transfers on all three channels at each rising edge.
    always @(posedge i_clk) begin
        int unsigned cnt;
        logic [63:0] n;
        logic [63:0] r;
        t_vertex_entry e;
        if (!i_rst_n) begin
            buf_count = 0;
            reg_res   = 8'd8;
            reg_dyn   = 1'b0;
            reg_tol   = 16'd1;
            o_errors  = 0;
            o_checked = 0;
            o_beliefs = 0;
            vertex_q.delete();
        end else begin
            // Configuration transfer.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RESOLUTION: reg_res = i_cfg_data[RES_W-1:0];
                    CFG_DYNAMIC:    reg_dyn = i_cfg_data[0];
                    CFG_TOLERANCE:  reg_tol = i_cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            // Entry transfer; the final or the eighth entry closes the belief.
            if (i_start && !i_busy) begin
                if (buf_count >= MAX_ENTRIES) buf_count = 0;
                buf_state[buf_count] = i_state_index;
                buf_prob[buf_count]  = 64'(i_probability);
                buf_count++;
                if (i_last_entry || buf_count >= MAX_ENTRIES) begin
                    cnt = buf_count;
                    buf_count = 0;
                    o_beliefs++;
                    n = (reg_res != 0) ? 64'(reg_res) : 64'd1;
                    r = n;
                    if (cnt == 1) buf_prob[0] = ONE;
                    else if (reg_dyn) r = best_resolution(n, cnt, 64'(reg_tol));
                    predict_vertices(r, cnt, 64'(reg_tol));
                end
            end
            // Result strobe.
            if (i_valid) begin
                if (vertex_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected result weight %h state %h", $realtime,
                                 i_vertex_weight, i_entry_state);
                end else begin
                    e = vertex_q.pop_front();
                    o_checked++;
                    if (e.weight !== i_vertex_weight || e.state !== i_entry_state ||
                        e.numer !== i_entry_numerator || e.res !== i_used_resolution ||
                        e.vend !== i_vertex_end || e.fin !== i_last) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("%0t: mismatch exp w=%h s=%h n=%0d r=%0d e=%b l=%b",
                                     $realtime, e.weight, e.state, e.numer, e.res,
                                     e.vend, e.fin);
                            $display("%0t:          got w=%h s=%h n=%0d r=%0d e=%b l=%b",
                                     $realtime, i_vertex_weight, i_entry_state,
                                     i_entry_numerator, i_used_resolution, i_vertex_end,
                                     i_last);
                        end
                    end
                end
            end
        end
        o_pending = vertex_q.size();
    end

endmodule

// File: tb/freudenthal_belief_triangulation_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// freudenthal_belief_triangulation_top_tb: testbench of the triangulation
// Feeds directed and random beliefs through several register settings, with
// random gaps on the entry channel, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module freudenthal_belief_triangulation_top_tb;
    import fbt_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic [STATE_W-1:0]    i_state_index;
    logic [PROB_W-1:0]     i_probability;
    logic                  i_last_entry;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_valid;
    logic [WEIGHT_W-1:0]   o_vertex_weight;
    logic [STATE_W-1:0]    o_entry_state;
    logic [RES_W-1:0]      o_entry_numerator;
    logic [RES_W-1:0]      o_used_resolution;
    logic                  o_vertex_end;
    logic                  o_last;

    int  errors;
    int  pending;
    int  checked;
    int  beliefs;
    int  entries_sent;
    bit  calm;

    freudenthal_belief_triangulation_top dut (.*);

    fbt_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_state_index, .i_probability,
        .i_last_entry, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_valid(o_valid), .i_vertex_weight(o_vertex_weight),
        .i_entry_state(o_entry_state), .i_entry_numerator(o_entry_numerator),
        .i_used_resolution(o_used_resolution), .i_vertex_end(o_vertex_end),
        .i_last(o_last), .o_errors(errors), .o_pending(pending),
        .o_checked(checked), .o_beliefs(beliefs)
    );

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // One entry transfer, with random gaps unless in the calm stretch.
    task automatic send_entry(logic [STATE_W-1:0] st, logic [PROB_W-1:0] p, logic lst);
        while (!calm && $urandom_range(99) < 37) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_state_index <= st;
        i_probability <= p;
        i_last_entry  <= lst;
        do @(posedge i_clk); while (o_busy);
        entries_sent++;
    endtask

    // Wait until the block has drained, then let it settle.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || o_busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // One register transfer on the configuration channel.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [15:0] res, logic dyn, logic [15:0] tol);
        write_reg(CFG_RESOLUTION, res);
        write_reg(CFG_DYNAMIC, 16'(dyn));
        write_reg(CFG_TOLERANCE, tol);
    endtask

    // A random belief: mostly a partition of one, sometimes grid aligned,
    // sometimes noise or an unterminated run that fills the buffer.
    task automatic send_belief();
        int unsigned n;
        int unsigned kind;
        int unsigned remain;
        int unsigned grid;
        int unsigned p;
        int unsigned st;
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(2, 4);
        kind = $urandom_range(99);
        remain = 65536;
        grid = $urandom_range(1, 12);
        st = $urandom_range(0, 65535 - 8 * 4096);
        for (int k = 0; k < n; k++) begin
            if (kind < 15) p = $urandom_range(65536);
            else if (k == n - 1) p = remain;
            else if (kind < 45) p = ((remain * grid / 65536) == 0) ? 0 :
                                    $urandom_range(remain * grid / 65536) * 65536 / grid;
            else p = $urandom_range(remain);
            if (p > remain && kind >= 15) p = remain;
            remain = (p > remain) ? 0 : remain - p;
            send_entry(16'(st), 17'(p), (kind < 8) ? 1'b0 : (k == n - 1));
            st += $urandom_range(1, 4096);
        end
        if (kind < 8) begin
            // Keep going until the buffer closes the belief itself.
            for (int k = n; k < 8; k++) begin
                send_entry(16'(st), 17'($urandom_range(65536)), 1'b0);
                st += $urandom_range(1, 4096);
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_state_index <= '0;
        i_probability <= '0;
        i_last_entry  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_RESOLUTION;
        i_cfg_data    <= '0;
        entries_sent  = 0;
        calm          = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset setting.
        send_entry(16'hFFFF, 17'd65536, 1'b1);
        send_entry(16'h0000, 17'd0, 1'b1);
        send_entry(16'h0000, 17'd32768, 1'b0);
        send_entry(16'hFFFF, 17'd32768, 1'b1);
        send_entry(16'h0001, 17'd65536, 1'b0);
        send_entry(16'h0002, 17'd65536, 1'b1);
        for (int k = 0; k < 8; k++) send_entry(16'(k * 9000), 17'(8192), 1'b0);
        send_entry(16'h1234, 17'h0FFFF, 1'b0);
        send_entry(16'h5678, 17'd1, 1'b1);
        drain();

        // Zero resolution, zero tolerance.
        set_regs(16'd0, 1'b0, 16'd0);
        send_entry(16'h0010, 17'd21845, 1'b0);
        send_entry(16'h0020, 17'd43691, 1'b1);
        drain();

        // Widest search, weights hidden by the largest tolerance.
        set_regs(16'hFFFF, 1'b1, 16'hFFFF);
        send_entry(16'h0003, 17'd10000, 1'b0);
        send_entry(16'h0004, 17'd55536, 1'b1);
        drain();
        set_regs(16'd255, 1'b1, 16'd0);
        send_entry(16'h0005, 17'd16384, 1'b0);
        send_entry(16'h0006, 17'd49152, 1'b1);
        send_entry(16'h0007, 17'd30000, 1'b0);
        send_entry(16'h0008, 17'd35536, 1'b1);
        drain();

        // Random part across several settings, with one calm stretch.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_regs(16'd8, 1'b0, 16'd1);
                1: set_regs(16'd1, 1'b0, 16'd0);
                2: set_regs(16'd12, 1'b1, 16'd64);
                3: set_regs(16'd255, 1'b0, 16'd1);
                4: set_regs(16'd20, 1'b1, 16'd2000);
                default: set_regs(16'($urandom_range(1, 40)), 1'($urandom_range(1)),
                                  16'($urandom_range(3) == 0 ? $urandom_range(65535)
                                                             : $urandom_range(300)));
            endcase
            calm = (ph == 3);
            while (entries_sent < 40 + ph * 32) send_belief();
            drain();
        end

        $display("Covered %0d beliefs from %0d entries, %0d vertex entries checked.",
                 beliefs, entries_sent, checked);
        $display("Settings spanned resolutions 0..255, both modes, tolerances 0..65535.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(12 * 2000000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/fbt_pkg.sv
rtl/fbt_cell.sv
rtl/freudenthal_belief_triangulation_top.sv
tb/fbt_checker.sv
tb/freudenthal_belief_triangulation_top_tb.sv
